/* rtl/core/odometry_pose_rebaser_assert.svh */
// Assertion macros shared by the pose rebaser RTL.
// They sample on clk and are disabled while rst_n is low in the module that uses them.
`ifndef ODOMETRY_POSE_REBASER_ASSERT_SVH
`define ODOMETRY_POSE_REBASER_ASSERT_SVH
// Implication checked on every rising edge of clk outside reset.
`define OPR_ASSERT_IMP(label, a, b, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// Next-cycle implication checked outside reset.
`define OPR_ASSERT_NXT(label, a, b, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

/* rtl/core/opr_pkg.sv */
// ----------------------------------------------------------------------------
// opr_pkg
// Types and constants shared by the pose rebaser modules.
// ----------------------------------------------------------------------------
package opr_pkg;
    typedef struct packed {
        logic               action;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] fused_x;
        logic signed [31:0] fused_y;
        logic        [15:0] fused_heading;
        logic signed [15:0] fused_quat_z;
        logic signed [15:0] fused_quat_w;
    } out_item_t;

    // Command to the shared CORDIC.
    typedef struct packed {
        logic               start;
        logic               vectoring;
        logic signed [39:0] x;
        logic signed [39:0] y;
        logic        [31:0] z;
    } cordic_cmd_t;

    typedef struct packed {
        logic               done;
        logic signed [39:0] x;
        logic signed [39:0] y;
        logic        [31:0] z;
    } cordic_rsp_t;

    localparam logic signed [39:0] GAIN_INV_Q30 = 40'sd652032874;
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0:  r = 32'h20000000;
                5'd1:  r = 32'h12E4051E;
                5'd2:  r = 32'h09FB385B;
                5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43;
                5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E;
                5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53;
                5'd9:  r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;
                5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;
                5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA;
                5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE;
                5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30;
                5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C;
                5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3;
                5'd23: r = 32'h00000051;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction
endpackage

/* rtl/core/opr_cordic.sv */
// ----------------------------------------------------------------------------
// opr_cordic
// Shared CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
// ----------------------------------------------------------------------------
module opr_cordic #(
    parameter int STEPS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  opr_pkg::cordic_cmd_t cmd,
    output opr_pkg::cordic_rsp_t rsp
);
    logic               busy_reg;
    logic [4:0]         step_reg;
    logic               vec_reg;
    logic signed [39:0] x_reg;
    logic signed [39:0] y_reg;
    logic [31:0]        z_reg;
    logic               done_reg;

    logic signed [39:0] xs;
    logic signed [39:0] ys;
    logic [31:0]        at;
    logic               plus;
    logic               hold;

    assign xs = x_reg >>> step_reg;
    assign ys = y_reg >>> step_reg;
    assign at = opr_pkg::atan_turn(step_reg);
    // Vectoring drives y to zero; rotation drives z to zero.
    assign plus = vec_reg ? (y_reg > 0) : !z_reg[31];
    assign hold = vec_reg && (y_reg == 0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                vec_reg  <= cmd.vectoring;
                x_reg    <= cmd.x;
                y_reg    <= cmd.y;
                z_reg    <= cmd.z;
            end
            else if (busy_reg)
            begin
                if (!hold)
                begin
                    if (vec_reg == plus)
                    begin
                        // vectoring y>0 or rotation z<0
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                    end
                    else
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                    end
                    z_reg <= (vec_reg == plus) ? z_reg + at : z_reg - at;
                end
                if (step_reg == 5'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 5'd1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.x = x_reg;
    assign rsp.y = y_reg;
    assign rsp.z = z_reg;

    `include "odometry_pose_rebaser_assert.svh"
    `OPR_ASSERT_NXT(a_done_pulse, done_reg, !done_reg, "done held two cycles")
    `OPR_ASSERT_IMP(a_no_restart, busy_reg, !cmd.start, "start while busy")
    `OPR_ASSERT_IMP(a_step_range, busy_reg, step_reg < 5'(STEPS), "step overrun")
endmodule

/* rtl/core/odometry_pose_rebaser.sv */
// An odometry item gives a result; a localization item or the origin item gives none.
// Throughput: one item at a time, set by the shared CORDIC; in_stall is high from acceptance
// until the result is loaded (or, for an item with no result, until the sequencer is back
// in idle), so the next item is taken in the cycle after that at the earliest.
// A stalled result holds the sequencer in its last state until the output register frees.
// Reset (asynchronous, rst_n low) clears all pose state and the origin latch.
// ----------------------------------------------------------------------------
// odometry_pose_rebaser
// Sequencer around one shared CORDIC and one multiplier for pose integration.
// ----------------------------------------------------------------------------
module odometry_pose_rebaser #(
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  opr_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output opr_pkg::out_item_t  out_data
);
    localparam int STEPS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    localparam int AB = ANGLE_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_M0, S_M1, S_M2, S_M3, S_YAW, S_YAW_W, S_BRANCH,
        S_R1, S_R1_W, S_P0, S_P1, S_P2, S_P3, S_R2, S_R2_W,
        S_Q0, S_Q1, S_Q2, S_Q3, S_FIN, S_SC, S_SC_W, S_OUT
    } state_t;

    state_t             state_reg;
    opr_pkg::in_item_t  item_reg;
    logic               origin_set_reg;
    logic [31:0]        origin_x_reg, origin_y_reg, prev_x_reg, prev_y_reg;
    logic [31:0]        pose_x_reg, pose_y_reg;
    logic [AB-1:0]      origin_h_reg, prev_h_reg, pose_h_reg;
    logic signed [39:0] acc_reg;
    logic signed [31:0] prod_reg;
    logic signed [63:0] acc64_reg;
    logic signed [31:0] dx_reg, dy_reg;
    logic [AB-1:0]      yaw_reg, dh_reg;
    logic signed [39:0] s_reg, c_reg;
    logic               flip_reg;
    logic               out_valid_reg;
    opr_pkg::out_item_t out_reg;

    opr_pkg::cordic_cmd_t cmd;
    opr_pkg::cordic_rsp_t rsp;

    opr_cordic #(.STEPS(STEPS)) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    // Shared multiplier operand selection.
    logic signed [31:0] ma, mb;
    logic signed [63:0] mprod;
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (state_reg)
            S_M0: begin ma = 32'(item_reg.quat_w); mb = 32'(item_reg.quat_z); end
            S_M1: begin ma = 32'(item_reg.quat_x); mb = 32'(item_reg.quat_y); end
            S_M2: begin ma = 32'(item_reg.quat_y); mb = 32'(item_reg.quat_y); end
            S_M3: begin ma = 32'(item_reg.quat_z); mb = 32'(item_reg.quat_z); end
            S_P0, S_Q0: begin ma = c_reg[31:0]; mb = dx_reg; end
            S_P1, S_Q1: begin ma = s_reg[31:0]; mb = dy_reg; end
            S_P2, S_Q2: begin ma = s_reg[31:0]; mb = dx_reg; end
            S_P3, S_Q3: begin ma = c_reg[31:0]; mb = dy_reg; end
            default: begin ma = '0; mb = '0; end
        endcase
        mprod = ma * mb;
    end

    function automatic logic [31:0] turn32(input logic [AB-1:0] a);
        logic [63:0] t;
        begin
            t = 64'(a) << (32 - AB);
            return t[31:0];
        end
    endfunction

    function automatic logic signed [31:0] rnd30(input logic signed [63:0] v);
        logic signed [63:0] t;
        begin
            t = (v + 64'sd536870912) >>> 30;
            return t[31:0];
        end
    endfunction

    function automatic logic signed [15:0] q14(input logic signed [39:0] v);
        logic signed [39:0] r;
        begin
            r = (v + 40'sd32768) >>> 16;
            if (r > 40'sd16384) r = 40'sd16384;
            if (r < -40'sd16384) r = -40'sd16384;
            return r[15:0];
        end
    endfunction

    logic [31:0] rot_turn;
    logic        rot_flip;
    logic [31:0] sc_angle;
    logic [AB-1:0] neg_origin;
    logic [63:0] yaw_round;
    assign neg_origin = '0 - origin_h_reg;
    assign sc_angle = turn32(pose_h_reg) >> 1;
    assign yaw_round = (64'(rsp.z) + (64'd1 << (31 - AB))) >> (32 - AB);

    always_comb
    begin
        case (state_reg)
            S_R2:    rot_turn = turn32(dh_reg);
            S_SC:    rot_turn = sc_angle;
            default: rot_turn = turn32(neg_origin);
        endcase
        rot_flip = ((rot_turn + opr_pkg::QUARTER_TURN) & opr_pkg::HALF_TURN) != 0;
    end

    always_comb
    begin
        cmd.start = 1'b0;
        cmd.vectoring = 1'b0;
        cmd.x = opr_pkg::GAIN_INV_Q30;
        cmd.y = '0;
        cmd.z = rot_flip ? rot_turn - opr_pkg::HALF_TURN : rot_turn;
        case (state_reg)
            S_YAW:
            begin
                // Half-plane fold for x < 0 is done before starting.
                cmd.start = 1'b1;
                cmd.vectoring = 1'b1;
                cmd.x = c_reg[39] ? -c_reg : c_reg;
                cmd.y = c_reg[39] ? -acc_reg : acc_reg;
                cmd.z = c_reg[39] ? opr_pkg::HALF_TURN : '0;
            end
            S_R1, S_R2, S_SC: cmd.start = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            origin_set_reg <= 1'b0;
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            origin_h_reg   <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            prev_h_reg     <= '0;
            pose_x_reg     <= '0;
            pose_y_reg     <= '0;
            pose_h_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        item_reg  <= in_data;
                        state_reg <= S_M0;
                    end
                S_M0:
                begin
                    acc64_reg <= mprod;
                    state_reg <= S_M1;
                end
                S_M1:
                begin
                    acc_reg   <= 40'((acc64_reg + mprod) <<< 1);
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    acc64_reg <= mprod;
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    c_reg     <= 40'sd268435456 - 40'((acc64_reg + mprod) <<< 1);
                    state_reg <= S_YAW;
                end
                S_YAW: state_reg <= S_YAW_W;
                S_YAW_W:
                    if (rsp.done)
                    begin
                        yaw_reg   <= yaw_round[AB-1:0];
                        state_reg <= S_BRANCH;
                    end
                S_BRANCH:
                begin
                    if (item_reg.action)
                    begin
                        pose_x_reg <= item_reg.pos_x;
                        pose_y_reg <= item_reg.pos_y;
                        pose_h_reg <= yaw_reg;
                        state_reg  <= S_IDLE;
                    end
                    else if (!origin_set_reg)
                    begin
                        origin_x_reg   <= item_reg.pos_x;
                        origin_y_reg   <= item_reg.pos_y;
                        origin_h_reg   <= yaw_reg;
                        origin_set_reg <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        dx_reg <= item_reg.pos_x - origin_x_reg - prev_x_reg;
                        dy_reg <= item_reg.pos_y - origin_y_reg - prev_y_reg;
                        prev_x_reg <= item_reg.pos_x - origin_x_reg;
                        prev_y_reg <= item_reg.pos_y - origin_y_reg;
                        dh_reg <= yaw_reg - origin_h_reg - prev_h_reg;
                        prev_h_reg <= yaw_reg - origin_h_reg;
                        state_reg <= S_R1;
                    end
                end
                S_R1:
                begin
                    flip_reg  <= rot_flip;
                    state_reg <= S_R1_W;
                end
                S_R2:
                begin
                    flip_reg  <= rot_flip;
                    state_reg <= S_R2_W;
                end
                S_R1_W, S_R2_W:
                    if (rsp.done)
                    begin
                        c_reg <= flip_reg ? -rsp.x : rsp.x;
                        s_reg <= flip_reg ? -rsp.y : rsp.y;
                        state_reg <= (state_reg == S_R1_W) ? S_P0 : S_Q0;
                    end
                S_P0, S_Q0:
                begin
                    acc64_reg <= mprod;
                    state_reg <= (state_reg == S_P0) ? S_P1 : S_Q1;
                end
                S_P1, S_Q1:
                begin
                    prod_reg  <= rnd30(acc64_reg - mprod);
                    state_reg <= (state_reg == S_P1) ? S_P2 : S_Q2;
                end
                S_P2, S_Q2:
                begin
                    acc64_reg <= mprod;
                    state_reg <= (state_reg == S_P2) ? S_P3 : S_Q3;
                end
                S_P3:
                begin
                    dx_reg    <= prod_reg;
                    dy_reg    <= rnd30(acc64_reg + mprod);
                    state_reg <= S_R2;
                end
                S_Q3:
                begin
                    pose_x_reg <= pose_x_reg + prod_reg;
                    pose_y_reg <= pose_y_reg + rnd30(acc64_reg + mprod);
                    pose_h_reg <= pose_h_reg + dh_reg;
                    state_reg  <= S_FIN;
                end
                S_FIN: state_reg <= S_SC;
                S_SC:
                begin
                    flip_reg  <= rot_flip;
                    state_reg <= S_SC_W;
                end
                S_SC_W:
                    if (rsp.done)
                        state_reg <= S_OUT;
                S_OUT:
                    // The CORDIC holds its result until the next start, so the
                    // item waits here while the previous result is still stalled.
                    if (!out_valid_reg)
                    begin
                        out_reg.fused_x       <= pose_x_reg;
                        out_reg.fused_y       <= pose_y_reg;
                        out_reg.fused_heading <= 16'(pose_h_reg);
                        out_reg.fused_quat_z  <= q14(flip_reg ? -rsp.y : rsp.y);
                        out_reg.fused_quat_w  <= q14(flip_reg ? -rsp.x : rsp.x);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `include "odometry_pose_rebaser_assert.svh"
    `OPR_ASSERT_IMP(a_out_src, $rose(out_valid_reg), $past(state_reg) == S_OUT, "stray result")
    `OPR_ASSERT_NXT(a_out_hold, out_valid_reg && out_stall, $stable(out_reg), "result moved")
    `OPR_ASSERT_IMP(a_idle_cordic, state_reg == S_IDLE, !cmd.start, "cordic started while idle")
endmodule

/* test/odometry_pose_rebaser_tb.sv */
// ----------------------------------------------------------------------------
// odometry_pose_rebaser_tb
// Drives odometry and localization items through the pose rebaser with random
// idling on both sides. A local predictor of the fused pose checks every result.
// ----------------------------------------------------------------------------
module odometry_pose_rebaser_tb;

    localparam int NUM_RANDOM = 1800;
    localparam int QUIET_TAIL = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam logic ACT_ODOM = 1'b0;
    localparam logic ACT_LOCALIZE = 1'b1;

    localparam logic [31:0] ARCTAN_TURN [16] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    opr_pkg::in_item_t   in_data;
    logic                out_valid;
    logic                out_stall;
    opr_pkg::out_item_t  out_data;

    odometry_pose_rebaser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    opr_pkg::in_item_t   pending_items [$];
    opr_pkg::out_item_t  expected_poses [$];
    int         errors;
    int         items_sent;
    int         total_items;
    int         drain_at;
    int         in_gap;
    int         out_gap;
    int         quiet_cycles;
    logic       in_fire;
    logic       stimulus_done;

    // Predictor state.
    logic        origin_latched;
    logic [31:0] org_x, org_y, last_rel_x, last_rel_y, fused_x, fused_y;
    logic [15:0] org_heading, last_rel_heading, fused_heading;

    function automatic logic [31:0] vector_angle(input longint y_in, input longint x_in);
        longint      x;
        longint      y;
        longint      xo;
        logic [31:0] z;
        x = x_in;
        y = y_in;
        z = '0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = opr_pkg::HALF_TURN;
        end
        for (int i = 0; i < 16; i++)
        begin
            xo = x;
            if (y > 0)
            begin
                x = x + (y >>> i);
                y = y - (xo >>> i);
                z = z + ARCTAN_TURN[i];
            end
            else if (y < 0)
            begin
                x = x - (y >>> i);
                y = y + (xo >>> i);
                z = z - ARCTAN_TURN[i];
            end
        end
        return z;
    endfunction

    // Sine and cosine in Q1.30 of an angle in 32-bit turn units.
    task automatic sin_cos(input logic [31:0] a_in, output longint s, output longint c);
        logic [31:0] a;
        logic [31:0] t;
        logic        flip;
        longint      x;
        longint      y;
        longint      z;
        longint      xo;
        a = a_in;
        t = a + opr_pkg::QUARTER_TURN;
        flip = t[31];
        if (flip)
            a = a - opr_pkg::HALF_TURN;
        x = longint'(opr_pkg::GAIN_INV_Q30);
        y = 0;
        z = longint'(signed'(a));
        for (int i = 0; i < 16; i++)
        begin
            xo = x;
            if (z >= 0)
            begin
                x = x - (y >>> i);
                y = y + (xo >>> i);
                z = z - longint'({32'd0, ARCTAN_TURN[i]});
            end
            else
            begin
                x = x + (y >>> i);
                y = y - (xo >>> i);
                z = z + longint'({32'd0, ARCTAN_TURN[i]});
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic rotate_step(inout longint x, inout longint y, input logic [15:0] ang);
        longint      s;
        longint      c;
        longint      rx;
        longint      ry;
        logic [31:0] tx;
        logic [31:0] ty;
        sin_cos({ang, 16'd0}, s, c);
        rx = (c * x - s * y + (longint'(1) <<< 29)) >>> 30;
        ry = (s * x + c * y + (longint'(1) <<< 29)) >>> 30;
        tx = rx[31:0];
        ty = ry[31:0];
        x = longint'(signed'(tx));
        y = longint'(signed'(ty));
    endtask

    function automatic logic [15:0] q14_of(input longint v);
        longint r;
        r = (v + (longint'(1) <<< 15)) >>> 16;
        if (r > 16384)
            r = 16384;
        if (r < -16384)
            r = -16384;
        return r[15:0];
    endfunction

    function automatic logic [15:0] yaw_of(input opr_pkg::in_item_t it);
        longint      qx;
        longint      qy;
        longint      qz;
        longint      qw;
        longint      num;
        longint      den;
        logic [63:0] r;
        qx = longint'(it.quat_x);
        qy = longint'(it.quat_y);
        qz = longint'(it.quat_z);
        qw = longint'(it.quat_w);
        num = 2 * (qw * qz + qx * qy);
        den = (longint'(1) <<< 28) - 2 * (qy * qy + qz * qz);
        r = ({32'd0, vector_angle(num, den)} + 64'h8000) >> 16;
        return r[15:0];
    endfunction

    task automatic integrate_pose(input opr_pkg::in_item_t it);
        logic [15:0] yaw;
        logic [31:0] rx;
        logic [31:0] ry;
        logic [31:0] d;
        logic [15:0] rh;
        logic [15:0] dh;
        longint      dx;
        longint      dy;
        longint      s;
        longint      c;
        opr_pkg::out_item_t pose;
        yaw = yaw_of(it);
        if (it.action == ACT_LOCALIZE)
        begin
            fused_x = it.pos_x;
            fused_y = it.pos_y;
            fused_heading = yaw;
        end
        else if (!origin_latched)
        begin
            org_x = it.pos_x;
            org_y = it.pos_y;
            org_heading = yaw;
            origin_latched = 1'b1;
        end
        else
        begin
            rx = it.pos_x - org_x;
            ry = it.pos_y - org_y;
            rh = yaw - org_heading;
            d = rx - last_rel_x;
            dx = longint'(signed'(d));
            d = ry - last_rel_y;
            dy = longint'(signed'(d));
            dh = rh - last_rel_heading;
            rotate_step(dx, dy, 16'd0 - org_heading);
            rotate_step(dx, dy, dh);
            fused_x = fused_x + dx[31:0];
            fused_y = fused_y + dy[31:0];
            fused_heading = fused_heading + dh;
            last_rel_x = rx;
            last_rel_y = ry;
            last_rel_heading = rh;
            sin_cos({fused_heading, 16'd0} >> 1, s, c);
            pose.fused_x = fused_x;
            pose.fused_y = fused_y;
            pose.fused_heading = fused_heading;
            pose.fused_quat_z = q14_of(s);
            pose.fused_quat_w = q14_of(c);
            expected_poses.push_back(pose);
        end
    endtask

    function automatic opr_pkg::in_item_t make_item(input logic act, input logic [31:0] x,
                                                    input logic [31:0] y,
                                                    input logic [15:0] qx,
                                                    input logic [15:0] qy,
                                                    input logic [15:0] qz,
                                                    input logic [15:0] qw);
        opr_pkg::in_item_t it;
        it.action = act;
        it.pos_x = x;
        it.pos_y = y;
        it.quat_x = qx;
        it.quat_y = qy;
        it.quat_z = qz;
        it.quat_w = qw;
        return it;
    endfunction

    // Pure yaw quaternion for a heading given in turns.
    function automatic opr_pkg::in_item_t yaw_item(input logic act, input logic [31:0] x,
                                                   input logic [31:0] y, input real turns);
        real half;
        half = turns * 3.14159265358979;
        return make_item(act, x, y, 16'd0, 16'd0, 16'($rtoi($sin(half) * 16384.0)),
                         16'($rtoi($cos(half) * 16384.0)));
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        logic [31:0] px;
        logic [31:0] py;
        real         hd;
        int          n;
        rst_n = 1'b0;
        stimulus_done = 1'b0;
        // Localization before any odometry, then the origin item.
        pending_items.push_back(yaw_item(ACT_LOCALIZE, 32'h0001_0000, 32'hFFFF_0000, 0.125));
        pending_items.push_back(make_item(ACT_ODOM, 0, 0, 16'd0, 16'd0, 16'd0, 16'd0));
        pending_items.push_back(make_item(ACT_ODOM, 32'h0000_8000, 0, 16'd0, 16'd0, 16'd0,
                                          16'd16384));
        pending_items.push_back(make_item(ACT_ODOM, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0,
                                          16'd0, 16'd16384, 16'd0));
        pending_items.push_back(make_item(ACT_ODOM, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0,
                                          16'd0, -16'sd16384, 16'd0));
        pending_items.push_back(make_item(ACT_ODOM, 32'h8000_0000, 32'h8000_0000, 16'h8000,
                                          16'h8000, 16'h8000, 16'h8000));
        pending_items.push_back(make_item(ACT_ODOM, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF,
                                          16'h7FFF, 16'h7FFF, 16'h7FFF));
        pending_items.push_back(make_item(ACT_ODOM, 1, 1, 16'd16384, 16'd0, 16'd0, 16'd0));
        pending_items.push_back(make_item(ACT_ODOM, 0, 0, 16'd0, 16'd16384, 16'd0, 16'd0));
        pending_items.push_back(make_item(ACT_ODOM, 0, 0, 16'd0, 16'd0, 16'd0, 16'd0));
        pending_items.push_back(yaw_item(ACT_ODOM, 32'h0002_0000, 32'h0001_0000, 0.5));
        pending_items.push_back(yaw_item(ACT_ODOM, 32'h0003_0000, 32'h0001_0000, -0.25));
        pending_items.push_back(yaw_item(ACT_LOCALIZE, 32'h8000_0000, 32'h7FFF_FFFF, 0.999));
        pending_items.push_back(yaw_item(ACT_ODOM, 32'h0003_8000, 32'h0001_4000, -0.24));
        pending_items.push_back(make_item(ACT_LOCALIZE, 32'hFFFF_FFFF, 0, 16'hFFFF, 16'hFFFF,
                                          16'hFFFF, 16'hFFFF));
        // Mostly a wandering robot with small steps; some items are raw noise.
        px = $urandom;
        py = $urandom;
        hd = 0.0;
        for (int k = 0; k < NUM_RANDOM; k++)
        begin
            n = $urandom_range(0, 99);
            if (n < 8)
                pending_items.push_back(make_item(1'($urandom), $urandom, $urandom,
                                                  16'($urandom), 16'($urandom),
                                                  16'($urandom), 16'($urandom)));
            else if (n < 14)
            begin
                px = $urandom;
                py = $urandom;
                hd = $urandom_range(0, 1000) / 1000.0;
                pending_items.push_back(yaw_item(ACT_LOCALIZE, px, py, hd));
            end
            else
            begin
                px = px + 32'($signed($urandom_range(0, 262144)) - 131072);
                py = py + 32'($signed($urandom_range(0, 262144)) - 131072);
                hd = hd + ($signed($urandom_range(0, 200)) - 100) / 1000.0;
                pending_items.push_back(yaw_item(ACT_ODOM, px, py, hd));
            end
        end
        total_items = pending_items.size();
        drain_at = total_items / 2;
        repeat (12) @(posedge clk);
        rst_n = 1'b1;
        @(posedge clk);
        while (pending_items.size() != 0 || in_valid || expected_poses.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        stimulus_done = 1'b1;
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Input driver.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            in_gap = 0;
            items_sent = 0;
        end
        else if (!in_valid || in_fire)
        begin
            if (in_gap > 0)
            begin
                in_gap = in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (items_sent == drain_at && expected_poses.size() != 0)
                in_valid <= 1'b0;
            else if (pending_items.size() != 0)
            begin
                in_data <= pending_items.pop_front();
                in_valid <= 1'b1;
                items_sent = items_sent + 1;
                if (items_sent < total_items - QUIET_TAIL && $urandom_range(0, 5) == 0)
                    in_gap = $urandom_range(1, 5);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result receiver stall.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap = 0;
        end
        else if (out_gap > 0)
        begin
            out_gap = out_gap - 1;
            out_stall <= 1'b1;
        end
        else if (items_sent < total_items - QUIET_TAIL && $urandom_range(0, 7) == 0)
        begin
            out_gap = $urandom_range(0, 4);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Monitor: predicts on accepted inputs and checks accepted results.
    always @(posedge clk or negedge rst_n)
    begin
        opr_pkg::out_item_t want;
        if (!rst_n)
        begin
            in_fire <= 1'b0;
            errors = 0;
            quiet_cycles = 0;
            origin_latched = 1'b0;
            {org_x, org_y, last_rel_x, last_rel_y, fused_x, fused_y} = '0;
            {org_heading, last_rel_heading, fused_heading} = '0;
        end
        else
        begin
            in_fire <= in_valid && !in_stall;
            quiet_cycles = quiet_cycles + 1;
            if (in_valid && !in_stall)
            begin
                quiet_cycles = 0;
                integrate_pose(in_data);
            end
            if (out_valid && !out_stall)
            begin
                quiet_cycles = 0;
                if (expected_poses.size() == 0)
                begin
                    errors = errors + 1;
                    $display("%0t: unexpected pose x=%h y=%h hd=%h", $time,
                             out_data.fused_x, out_data.fused_y, out_data.fused_heading);
                end
                else
                begin
                    want = expected_poses.pop_front();
                    if (want.fused_x !== out_data.fused_x)
                        $display("%0t: fused_x expected %h actual %h", $time,
                                 want.fused_x, out_data.fused_x);
                    if (want.fused_y !== out_data.fused_y)
                        $display("%0t: fused_y expected %h actual %h", $time,
                                 want.fused_y, out_data.fused_y);
                    if (want.fused_heading !== out_data.fused_heading)
                        $display("%0t: fused_heading expected %h actual %h", $time,
                                 want.fused_heading, out_data.fused_heading);
                    if (want.fused_quat_z !== out_data.fused_quat_z)
                        $display("%0t: fused_quat_z expected %h actual %h", $time,
                                 want.fused_quat_z, out_data.fused_quat_z);
                    if (want.fused_quat_w !== out_data.fused_quat_w)
                        $display("%0t: fused_quat_w expected %h actual %h", $time,
                                 want.fused_quat_w, out_data.fused_quat_w);
                    if (want !== out_data)
                        errors = errors + 1;
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT && !stimulus_done)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end
endmodule
